### rtl/tib_pkg.sv
// Shared types and constants for the tent intensity binner.
// No dependencies; imported by tent_intensity_binner.
package tib_pkg;

    // Command codes of an input item
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes
    localparam logic REG_BIN_WIDTH      = 1'b0;
    localparam logic REG_SPECTRAL_WIDTH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [30:0] BIN_WIDTH_RST      = 31'd16;
    localparam logic [30:0] SPECTRAL_WIDTH_RST = 31'd65536;

    // Q1.30 constants for the cumulative area
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [55:0] Q30_HALF = 56'h20000000;

    // Accumulator limits
    localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] ACC_MIN = -49'sh0_8000_0000_0000;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] center_offset;
        logic signed [31:0] freq_low;
        logic signed [31:0] freq_peak;
        logic signed [31:0] freq_high;
        logic signed [23:0] amp_real;
        logic signed [23:0] amp_imag;
        logic        [11:0] read_bin;
    } tib_in_t;

    typedef struct packed {
        logic signed [47:0] bin_real;
        logic signed [47:0] bin_imag;
        logic               is_read;
    } tib_out_t;

endpackage

### rtl/tib_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tib_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/tent_intensity_binner.sv
// Tent intensity binner top level: sequencer, shared divider and multiplier.
// Depends on tib_pkg and tib_ram.
//
// Usage: a complex spectrum of NUM_POINTS bins held in one RAM. An input item
// (valid/ready) either adds a unit-area triangular tent times a complex
// amplitude, or reads one bin. Each item gives one result item (valid/ready):
// the bin value for a read, zeros with is_read low for an add.
// After reset a clearing pass writes zero to every bin, one per cycle; no item
// is taken meanwhile. Configuration writes (bin_width, spectral_width) are
// taken at any time. A read passes through S_RD1, S_RD2 and S_DONE to its
// result. An add first runs setup (two 33-step integer divisions for the first
// and last bin), then works through each covered bin: each bin boundary inside
// the tent needs two 31-step restoring divisions on the one shared divider,
// plus the shared multiplier for the boundary, the area product and the two
// amplitude scalings. A degenerate tent needs at most one integer division.
// The block takes one item at a time; in_ready is high only when idle.
// A finished result waits in the output register while the receiver stalls,
// and the next item may be taken meanwhile; its result is held until the
// output register frees up.
module tent_intensity_binner #(
    parameter int NUM_POINTS = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tib_pkg::tib_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output tib_pkg::tib_out_t out_item,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [30:0]       cfg_data
);

    import tib_pkg::*;

    localparam int AW = $clog2(NUM_POINTS);
    localparam logic [5:0] DIV_INT_STEPS  = 6'd33;
    localparam logic [5:0] DIV_FRAC_STEPS = 6'd31;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_SETUP, S_DEG_K, S_DEG_RD, S_K0, S_K1,
        S_BIN_HI, S_BIN_HI2, S_CDF, S_CDF_P, S_CDF_Q, S_CDF_M, S_CDF_END,
        S_SCALE_RE, S_SCALE_IM, S_SCALE_END, S_WRITE, S_DONE, S_DIV
    } state_t;

    // Control registers
    state_t      state_reg, state_next, ret_reg, ret_next;
    logic [32:0] k_reg, k_next;
    logic        first_reg, first_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] bw_reg, sw_reg;

    // Payload registers
    logic signed [34:0] a_reg, a_next, m_reg, m_next, b_reg, b_next;
    logic signed [34:0] lo_e_reg, lo_e_next, hi_e_reg, hi_e_next, f_reg, f_next;
    logic               deg_reg, deg_next, unord_reg, unord_next;
    logic signed [23:0] amp_re_reg, amp_re_next, amp_im_reg, amp_im_next;
    logic [32:0]        k1_reg, k1_next;
    logic [33:0]        d_reg, d_next;
    logic               fall_reg, fall_next;
    logic [30:0]        flo_reg, flo_next, fcur_reg, fcur_next;
    logic [30:0]        p_reg, p_next, x_reg, x_next;
    logic [61:0]        prod_reg, prod_next;
    logic signed [24:0] dre_reg, dre_next, dim_reg, dim_next;
    logic [33:0]        div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [32:0]        div_dvd_reg, div_dvd_next, div_q_reg, div_q_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic               rd_ok_reg, rd_ok_next;
    tib_out_t           res_reg, res_next, out_item_reg, out_item_next;

    // RAM and datapath signals
    logic               ram_we;
    logic [95:0]        ram_wdata, ram_rdata;
    logic [34:0]        div_trial;
    logic               div_ge;
    logic [33:0]        div_rem_step;
    logic [30:0]        mul_a, mul_b;
    logic [61:0]        mul_p;
    logic [30:0]        bw_eff;
    logic signed [47:0] rd_re, rd_im;
    logic signed [48:0] sum_re, sum_im;
    logic signed [47:0] sat_re, sat_im;
    logic [23:0]        mag_re, mag_im;
    logic [55:0]        rnd_sum;
    logic signed [24:0] rnd_val;

    tib_ram #(
        .WIDTH (96),
        .DEPTH (NUM_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (k_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign bw_eff    = (bw_reg == 31'd0) ? 31'd1 : bw_reg;

    // One restoring division step
    assign div_trial    = {div_rem_reg, div_dvd_reg[32]};
    assign div_ge       = div_trial >= {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? 34'(div_trial - {1'b0, div_den_reg}) : div_trial[33:0];

    // Shared multiplier operand selection
    assign mag_re = amp_re_reg[23] ? 24'(-amp_re_reg) : 24'(amp_re_reg);
    assign mag_im = amp_im_reg[23] ? 24'(-amp_im_reg) : 24'(amp_im_reg);

    always_comb
    begin
        unique case (state_reg)
            S_BIN_HI:
            begin
                mul_a = 31'(k_reg + 33'd1);
                mul_b = bw_eff;
            end
            S_CDF_Q:
            begin
                mul_a = p_reg;
                mul_b = div_q_reg[30:0];
            end
            S_SCALE_RE:
            begin
                mul_a = x_reg;
                mul_b = 31'(mag_re);
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = 31'(mag_im);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Round the scaled share to nearest, halves away from zero
    assign rnd_sum = 56'(prod_reg) + Q30_HALF;
    assign rnd_val = $signed(rnd_sum[54:30]);

    // Saturating accumulate
    assign rd_re  = $signed(ram_rdata[95:48]);
    assign rd_im  = $signed(ram_rdata[47:0]);
    assign sum_re = 49'(rd_re) + 49'(dre_reg);
    assign sum_im = 49'(rd_im) + 49'(dim_reg);
    assign sat_re = (sum_re > ACC_MAX) ? ACC_MAX[47:0] :
                    (sum_re < ACC_MIN) ? ACC_MIN[47:0] : sum_re[47:0];
    assign sat_im = (sum_im > ACC_MAX) ? ACC_MAX[47:0] :
                    (sum_im < ACC_MIN) ? ACC_MIN[47:0] : sum_im[47:0];

    // Sequencer next-state and datapath logic
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        m_next         = m_reg;
        b_next         = b_reg;
        lo_e_next      = lo_e_reg;
        hi_e_next      = hi_e_reg;
        f_next         = f_reg;
        deg_next       = deg_reg;
        unord_next     = unord_reg;
        amp_re_next    = amp_re_reg;
        amp_im_next    = amp_im_reg;
        k1_next        = k1_reg;
        d_next         = d_reg;
        fall_next      = fall_reg;
        flo_next       = flo_reg;
        fcur_next      = fcur_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        dre_next       = dre_reg;
        dim_next       = dim_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_dvd_next   = div_dvd_reg;
        div_q_next     = div_q_reg;
        rd_addr_next   = rd_addr_reg;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        ram_wdata      = {sat_re, sat_im};

        // Drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (k_reg[AW-1:0] == AW'(NUM_POINTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 33'd1;
                end
            end

            S_IDLE:
            begin
                // Latch the item
                if (in_valid)
                begin
                    a_next = 35'($signed(in_item.center_offset)) + 35'($signed(in_item.freq_low));
                    m_next = 35'($signed(in_item.center_offset)) + 35'($signed(in_item.freq_peak));
                    b_next = 35'($signed(in_item.center_offset)) + 35'($signed(in_item.freq_high));
                    deg_next   = (in_item.freq_low == in_item.freq_high);
                    unord_next = (in_item.freq_peak < in_item.freq_low) ||
                                 (in_item.freq_peak > in_item.freq_high);
                    amp_re_next  = in_item.amp_real;
                    amp_im_next  = in_item.amp_imag;
                    rd_addr_next = AW'(in_item.read_bin);
                    rd_ok_next   = (32'(in_item.read_bin) < 32'(NUM_POINTS));
                    res_next     = '0;
                    state_next   = (in_item.cmd == CMD_READ) ? S_RD1 : S_SETUP;
                end
            end

            S_RD1:
            begin
                state_next = S_RD2;
            end

            S_RD2:
            begin
                res_next.is_read = 1'b1;
                if (rd_ok_reg)
                begin
                    res_next.bin_real = rd_re;
                    res_next.bin_imag = rd_im;
                end
                state_next = S_DONE;
            end

            S_SETUP:
            begin
                lo_e_next = (a_reg < 35'sd0) ? 35'sd0 : a_reg;
                hi_e_next = (b_reg < $signed({4'b0, sw_reg})) ? b_reg : $signed({4'b0, sw_reg});
                dre_next  = 25'(amp_re_reg);
                dim_next  = 25'(amp_im_reg);
                priority if (deg_reg)
                begin
                    // Whole amplitude into one bin
                    if (a_reg < 35'sd0)
                    begin
                        k_next       = '0;
                        k1_next      = '0;
                        rd_addr_next = '0;
                        state_next   = S_DEG_RD;
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_dvd_next = a_reg[32:0];
                        div_den_next = {3'b0, bw_eff};
                        div_q_next   = '0;
                        div_cnt_next = DIV_INT_STEPS;
                        ret_next     = S_DEG_K;
                        state_next   = S_DIV;
                    end
                end
                else if (unord_reg || (lo_e_next >= hi_e_next))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    div_rem_next = '0;
                    div_dvd_next = lo_e_next[32:0];
                    div_den_next = {3'b0, bw_eff};
                    div_q_next   = '0;
                    div_cnt_next = DIV_INT_STEPS;
                    ret_next     = S_K0;
                    state_next   = S_DIV;
                end
            end

            S_DEG_K:
            begin
                k_next  = div_q_reg;
                k1_next = div_q_reg;
                if (div_q_reg >= 33'(NUM_POINTS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr_next = div_q_reg[AW-1:0];
                    state_next   = S_DEG_RD;
                end
            end

            S_DEG_RD:
            begin
                state_next = S_WRITE;
            end

            S_K0:
            begin
                k_next       = div_q_reg;
                div_rem_next = '0;
                div_dvd_next = 33'(hi_e_reg - 35'sd1);
                div_den_next = {3'b0, bw_eff};
                div_q_next   = '0;
                div_cnt_next = DIV_INT_STEPS;
                ret_next     = S_K1;
                state_next   = S_DIV;
            end

            S_K1:
            begin
                k1_next = (div_q_reg > 33'(NUM_POINTS - 1)) ? 33'(NUM_POINTS - 1) : div_q_reg;
                if (k_reg > k1_next)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    f_next     = lo_e_reg;
                    first_next = 1'b1;
                    state_next = S_CDF;
                end
            end

            S_BIN_HI:
            begin
                // Upper edge of bin k, and fetch the bin
                prod_next    = mul_p;
                rd_addr_next = k_reg[AW-1:0];
                state_next   = S_BIN_HI2;
            end

            S_BIN_HI2:
            begin
                f_next     = (prod_reg > 62'(hi_e_reg)) ? hi_e_reg : $signed(35'(prod_reg));
                state_next = S_CDF;
            end

            S_CDF:
            begin
                // Classify the boundary against the tent
                priority if (f_reg <= a_reg)
                begin
                    fcur_next  = '0;
                    state_next = S_CDF_END;
                end
                else if (f_reg >= b_reg)
                begin
                    fcur_next  = Q30_ONE;
                    state_next = S_CDF_END;
                end
                else
                begin
                    fall_next    = (f_reg > m_reg);
                    d_next       = (f_reg > m_reg) ? 34'(b_reg - f_reg) : 34'(f_reg - a_reg);
                    div_den_next = (f_reg > m_reg) ? 34'(b_reg - m_reg) : 34'(m_reg - a_reg);
                    div_rem_next = {1'b0, d_next[33:1]};
                    div_dvd_next = {d_next[0], 32'b0};
                    div_q_next   = '0;
                    div_cnt_next = DIV_FRAC_STEPS;
                    ret_next     = S_CDF_P;
                    state_next   = S_DIV;
                end
            end

            S_CDF_P:
            begin
                p_next       = div_q_reg[30:0];
                div_den_next = 34'(b_reg - a_reg);
                div_rem_next = {1'b0, d_reg[33:1]};
                div_dvd_next = {d_reg[0], 32'b0};
                div_q_next   = '0;
                div_cnt_next = DIV_FRAC_STEPS;
                ret_next     = S_CDF_Q;
                state_next   = S_DIV;
            end

            S_CDF_Q:
            begin
                prod_next  = mul_p;
                state_next = S_CDF_M;
            end

            S_CDF_M:
            begin
                fcur_next  = fall_reg ? (Q30_ONE - prod_reg[60:30]) : prod_reg[60:30];
                state_next = S_CDF_END;
            end

            S_CDF_END:
            begin
                if (first_reg)
                begin
                    flo_next   = fcur_reg;
                    first_next = 1'b0;
                    state_next = S_BIN_HI;
                end
                else
                begin
                    x_next     = (fcur_reg > flo_reg) ? (fcur_reg - flo_reg) : 31'd0;
                    state_next = S_SCALE_RE;
                end
            end

            S_SCALE_RE:
            begin
                prod_next  = mul_p;
                state_next = S_SCALE_IM;
            end

            S_SCALE_IM:
            begin
                dre_next   = amp_re_reg[23] ? -rnd_val : rnd_val;
                prod_next  = mul_p;
                state_next = S_SCALE_END;
            end

            S_SCALE_END:
            begin
                dim_next   = amp_im_reg[23] ? -rnd_val : rnd_val;
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                // Accumulate into bin k and advance
                ram_we = 1'b1;
                if (k_reg == k1_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 33'd1;
                    flo_next   = fcur_reg;
                    state_next = S_BIN_HI;
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            S_DIV:
            begin
                div_rem_next = div_rem_step;
                div_dvd_next = {div_dvd_reg[31:0], 1'b0};
                div_q_next   = {div_q_reg[31:0], div_ge};
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd1)
                begin
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            bw_reg        <= BIN_WIDTH_RST;
            sw_reg        <= SPECTRAL_WIDTH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_BIN_WIDTH))
            begin
                bw_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_SPECTRAL_WIDTH))
            begin
                sw_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        m_reg        <= m_next;
        b_reg        <= b_next;
        lo_e_reg     <= lo_e_next;
        hi_e_reg     <= hi_e_next;
        f_reg        <= f_next;
        deg_reg      <= deg_next;
        unord_reg    <= unord_next;
        amp_re_reg   <= amp_re_next;
        amp_im_reg   <= amp_im_next;
        k1_reg       <= k1_next;
        d_reg        <= d_next;
        fall_reg     <= fall_next;
        flo_reg      <= flo_next;
        fcur_reg     <= fcur_next;
        p_reg        <= p_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        dre_reg      <= dre_next;
        dim_reg      <= dim_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        div_dvd_reg  <= div_dvd_next;
        div_q_reg    <= div_q_next;
        rd_addr_reg  <= rd_addr_next;
        rd_ok_reg    <= rd_ok_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

endmodule
